>>> src/lbr_pkg.sv
// Shared types and constants of the lazy block RAM bus device.
`default_nettype none

package lbr_pkg;

	localparam int ADDR_W    = 32;
	localparam int CNT_W     = 4;
	localparam int DATA_W    = 64;
	localparam int ROW_BYTES = 8;

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_UNMAPPED = 2'd1,
		ST_FAULT    = 2'd2
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic go_first;
		logic go_second;
		logic clr_start;
		logic clr_step;
		logic clr_done;
		logic wr_req;
		logic rd_req;
		logic rd_cap;
		logic finish;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic unmapped;
		logic empty;
		logic two_rows;
		logic on_second;
		logic is_write;
		logic alloc_hit;
		logic clr_last;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

>>> src/lbr_ctrl.sv
// Sequencing controller of the lazy block RAM bus device.
`default_nettype none

module lbr_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire lbr_pkg::dp_stat_t stat,
	output lbr_pkg::dp_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_PROBE,
		S_CLEAR,
		S_WRITE,
		S_RDWAIT,
		S_DONE
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   more_row;

	assign in_ready = in_ready_q;
	assign more_row = stat.two_rows && !stat.on_second;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_ready_q <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready_q) begin
						state_q    <= S_CHECK;
						in_ready_q <= 1'b0;
					end
				end
				S_CHECK: begin
					if (stat.unmapped || stat.empty) state_q <= S_DONE;
					else                             state_q <= S_PROBE;
				end
				S_PROBE: begin
					if (!stat.is_write)     state_q <= S_RDWAIT;
					else if (stat.alloc_hit) state_q <= S_WRITE;
					else                    state_q <= S_CLEAR;
				end
				S_CLEAR: begin
					if (stat.clr_last) state_q <= S_WRITE;
				end
				S_WRITE, S_RDWAIT: begin
					if (more_row) state_q <= S_PROBE;
					else          state_q <= S_DONE;
				end
				S_DONE: begin
					if (stat.out_free) begin
						state_q    <= S_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= S_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == S_IDLE) && in_valid && in_ready_q;
		cmd.go_first  = (state_q == S_CHECK) && !(stat.unmapped || stat.empty);
		cmd.clr_start = (state_q == S_PROBE) && stat.is_write && !stat.alloc_hit;
		cmd.rd_req    = (state_q == S_PROBE) && !stat.is_write;
		cmd.clr_step  = (state_q == S_CLEAR);
		cmd.clr_done  = (state_q == S_CLEAR) && stat.clr_last;
		cmd.wr_req    = (state_q == S_WRITE);
		cmd.rd_cap    = (state_q == S_RDWAIT);
		cmd.go_second = ((state_q == S_WRITE) || (state_q == S_RDWAIT)) && more_row;
		cmd.finish    = (state_q == S_DONE) && stat.out_free;
	end

endmodule

`default_nettype wire

>>> src/lbr_dp.sv
// Datapath: item registers, row RAM, allocation bits, result register.
`default_nettype none

module lbr_dp #(
	parameter int BLOCK_COUNT      = 64,
	parameter int BLOCK_BYTES      = 256,
	parameter int MAX_ACCESS_BYTES = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic                         cfg_wr_data,
	input  wire logic                         in_command,
	input  wire logic [lbr_pkg::ADDR_W-1:0]   in_address,
	input  wire logic [lbr_pkg::CNT_W-1:0]    in_count,
	input  wire logic [lbr_pkg::DATA_W-1:0]   in_wdata,
	input  wire lbr_pkg::dp_cmd_t              cmd,
	output lbr_pkg::dp_stat_t                  stat,
	input  wire logic                         out_ready,
	output logic                              out_valid,
	output logic [lbr_pkg::DATA_W-1:0]        out_data,
	output logic [1:0]                        out_status
);

	// BLOCK_BYTES is a power of two, so a row never straddles two blocks
	localparam int RPB        = BLOCK_BYTES / lbr_pkg::ROW_BYTES;
	localparam int RPB_SHIFT  = $clog2(RPB);
	localparam int RPB_AW     = (RPB > 1) ? RPB_SHIFT : 1;
	localparam int TOTAL_ROWS = BLOCK_COUNT * RPB;
	localparam int ROW_AW     = (TOTAL_ROWS > 1) ? $clog2(TOTAL_ROWS) : 1;
	localparam int BLK_AW     = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
	localparam logic [32:0] TOTAL_BYTES = 33'(BLOCK_COUNT) * 33'(BLOCK_BYTES);
	localparam logic [lbr_pkg::CNT_W-1:0] MAX_CNT = lbr_pkg::CNT_W'(MAX_ACCESS_BYTES);

	// item registers
	logic                        is_write_q;
	logic [lbr_pkg::ADDR_W-1:0]  addr_q;
	logic [lbr_pkg::CNT_W-1:0]   cnt_q;
	logic [lbr_pkg::DATA_W-1:0]  wdata_q;
	logic                        fault_q;
	logic [ROW_AW-1:0]           cur_row_q;
	logic                        on_second_q;
	logic [RPB_AW-1:0]           clr_cnt_q;
	logic                        rd_alloc_q;
	logic [lbr_pkg::DATA_W-1:0]  rd0_q;
	logic [lbr_pkg::DATA_W-1:0]  rd1_q;

	// control state
	logic                        mode_q;
	logic [BLOCK_COUNT-1:0]      alloc_q;
	logic                        out_valid_q;
	logic [lbr_pkg::DATA_W-1:0]  out_data_q;
	logic [1:0]                  out_status_q;

	// row RAM
	logic [lbr_pkg::DATA_W-1:0]  mem_q [TOTAL_ROWS];
	logic [lbr_pkg::DATA_W-1:0]  mem_rdata_q;
	logic [ROW_AW-1:0]           mem_addr;
	logic                        mem_we;
	logic [7:0]                  mem_be;
	logic [lbr_pkg::DATA_W-1:0]  mem_wd;

	logic [32:0]                 end_x;
	logic [32:0]                 last_x;
	logic [ROW_AW-1:0]           row0;
	logic [ROW_AW-1:0]           row1;
	logic [ROW_AW-1:0]           clr_row;
	logic [BLK_AW-1:0]           cur_blk;
	logic [2:0]                  off;
	logic [127:0]                wwin;
	logic [15:0]                 be16;
	logic [127:0]                rwin;
	logic [lbr_pkg::DATA_W-1:0]  keep;
	logic [lbr_pkg::DATA_W-1:0]  rword;
	logic [lbr_pkg::CNT_W-1:0]   sat_cnt;
	logic                        unmapped;
	logic                        empty;
	logic [lbr_pkg::DATA_W-1:0]  res_data;
	lbr_pkg::status_t            res_status;

	assign sat_cnt  = (in_count > MAX_CNT) ? MAX_CNT : in_count;
	assign end_x    = {1'b0, addr_q} + 33'(cnt_q);
	assign last_x   = end_x - 33'd1;
	assign row0     = addr_q[ROW_AW+2:3];
	assign row1     = last_x[ROW_AW+2:3];
	assign unmapped = ({1'b0, addr_q} >= TOTAL_BYTES) || (end_x > TOTAL_BYTES);
	assign empty    = (cnt_q == '0);
	assign cur_blk  = BLK_AW'(cur_row_q >> RPB_SHIFT);
	assign clr_row  = ROW_AW'((cur_row_q >> RPB_SHIFT) << RPB_SHIFT) | ROW_AW'(clr_cnt_q);
	assign off      = addr_q[2:0];

	// two-row byte window, lane j of the window is address row0*8 + j
	assign wwin = 128'(wdata_q) << {off, 3'b000};
	assign be16 = 16'(8'((9'd1 << cnt_q) - 9'd1)) << off;
	assign rwin = {rd1_q, rd0_q} >> {off, 3'b000};

	always_comb begin
		for (int l = 0; l < 8; l++) begin
			keep[8*l +: 8] = {8{(lbr_pkg::CNT_W'(l) < cnt_q)}};
		end
	end

	// never-written rows of an unallocated block read as zero
	assign rword = rd_alloc_q ? mem_rdata_q : '0;

	assign mem_we   = cmd.clr_step || cmd.wr_req;
	assign mem_addr = cmd.clr_step ? clr_row : cur_row_q;
	assign mem_be   = cmd.clr_step ? 8'hFF : (on_second_q ? be16[15:8] : be16[7:0]);
	assign mem_wd   = cmd.clr_step ? '0 : (on_second_q ? wwin[127:64] : wwin[63:0]);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			for (int l = 0; l < 8; l++) begin
				if (mem_be[l]) mem_q[mem_addr][8*l +: 8] <= mem_wd[8*l +: 8];
			end
		end
		mem_rdata_q <= mem_q[mem_addr];
	end

	always_comb begin
		res_data   = '0;
		res_status = lbr_pkg::ST_OK;
		if (unmapped) begin
			res_status = lbr_pkg::ST_UNMAPPED;
		end else if (is_write_q || empty) begin
			res_status = lbr_pkg::ST_OK;
		end else if (fault_q) begin
			res_status = lbr_pkg::ST_FAULT;
		end else begin
			res_data = rwin[63:0] & keep;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			is_write_q <= in_command;
			addr_q     <= in_address;
			cnt_q      <= sat_cnt;
			wdata_q    <= in_wdata;
			fault_q    <= 1'b0;
		end
		if (cmd.go_first) begin
			cur_row_q   <= row0;
			on_second_q <= 1'b0;
		end
		if (cmd.go_second) begin
			cur_row_q   <= row1;
			on_second_q <= 1'b1;
		end
		if (cmd.clr_start) clr_cnt_q <= '0;
		else if (cmd.clr_step) clr_cnt_q <= clr_cnt_q + RPB_AW'(1);
		if (cmd.rd_req) rd_alloc_q <= alloc_q[cur_blk];
		if (cmd.rd_cap) begin
			if (on_second_q) rd1_q <= rword;
			else             rd0_q <= rword;
			if (!rd_alloc_q && mode_q) fault_q <= 1'b1;
		end
		if (cmd.finish) begin
			out_data_q   <= res_data;
			out_status_q <= res_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			alloc_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) mode_q <= cfg_wr_data;
			if (cmd.clr_done) alloc_q[cur_blk] <= 1'b1;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;
	assign out_status = out_status_q;

	always_comb begin
		stat           = '0;
		stat.unmapped  = unmapped;
		stat.empty     = empty;
		stat.two_rows  = (row1 != row0);
		stat.on_second = on_second_q;
		stat.is_write  = (is_write_q == lbr_pkg::CMD_WRITE);
		stat.alloc_hit = alloc_q[cur_blk];
		stat.clr_last  = (clr_cnt_q == RPB_AW'(RPB - 1));
		stat.out_free  = !out_valid_q || out_ready;
	end

endmodule

`default_nettype wire

>>> src/lazy_block_ram_bus_device_top.sv
// Steps: check, then per touched row a probe and the row access, then the result;
// an access spanning two 8-byte rows probes twice, and unmapped or zero-length accesses
// go from check straight to the result. A write clears each unallocated block it
// touches first. One item in flight; s_tready returns the cycle after the result loads.
// The output register lets an item be taken while the previous result waits.
// Reset (arst_n low, async): all blocks unallocated, uninit_mode 0, no clearing pass.
`default_nettype none

module lazy_block_ram_bus_device_top #(
	parameter int BLOCK_COUNT      = 64,   // number of blocks
	parameter int BLOCK_BYTES      = 256,  // bytes per block, power of two, at least 8
	parameter int MAX_ACCESS_BYTES = 8     // byte counts above this saturate
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// mode register: 0 reads of unallocated blocks give zeros, 1 give access fault
	input  wire logic         cfg_wr_en,
	input  wire logic         cfg_wr_data,
	// request stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [103:0] s_tdata,   // address[31:0], byte_count[35:32],
	                                     // write_data[99:36], zero[103:100]
	input  wire logic         s_tuser,   // command: 0 read, 1 write
	// response stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [63:0]       m_tdata,   // read_data[63:0]
	output logic [1:0]        m_tuser    // status: 0 ok, 1 unmapped, 2 access fault
);

	lbr_pkg::dp_cmd_t  cmd;
	lbr_pkg::dp_stat_t stat;

	// controller walks check, per-row probe, optional block clear, row access, result
	lbr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath holds the item, the 64-bit row RAM and the allocation bits;
	// an access touches at most two rows, one per pass through probe
	lbr_dp #(
		.BLOCK_COUNT      (BLOCK_COUNT),
		.BLOCK_BYTES      (BLOCK_BYTES),
		.MAX_ACCESS_BYTES (MAX_ACCESS_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_command  (s_tuser),
		.in_address  (s_tdata[31:0]),
		.in_count    (s_tdata[35:32]),
		.in_wdata    (s_tdata[99:36]),
		.cmd         (cmd),
		.stat        (stat),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.out_data    (m_tdata),
		.out_status  (m_tuser)
	);

endmodule

`default_nettype wire

>>> src/lbr_check.sv
// Port-level checker of the lazy block RAM bus device and its bind.
`default_nettype none

module lbr_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [63:0] m_tdata,
	input wire logic [1:0]  m_tuser
);

	// one item in flight: ready drops right after an input transfer
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
	else $error("input taken while an item is in flight");

	// any non-ok status carries zero data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != lbr_pkg::ST_OK) |-> (m_tdata == '0))
	else $error("non-ok result with nonzero data");

	// status is a defined code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == lbr_pkg::ST_OK || m_tuser == lbr_pkg::ST_UNMAPPED ||
		              m_tuser == lbr_pkg::ST_FAULT))
	else $error("undefined status code");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	else $error("stalled result changed");

endmodule

bind lazy_block_ram_bus_device_top lbr_check u_lbr_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

>>> tb/lazy_block_ram_bus_device_top_tb.sv
// Testbench for the lazy block RAM bus device: directed and random accesses, predictor checks.
`timescale 1ns / 100ps

module lazy_block_ram_bus_device_top_tb;

	// geometry of the instance under test (block defaults)
	localparam int BLK_COUNT = 64;
	localparam int BLK_BYTES = 256;
	localparam int MAX_BYTES = 8;
	localparam longint unsigned CAPACITY = 64'(BLK_COUNT) * 64'(BLK_BYTES);

	// watchdog: cycles with no transfer on either stream before giving up;
	// covers a HOLD_CYCLES receiver hold plus two block clears
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 12;

	typedef struct packed {
		logic [63:0]      read_data;
		lbr_pkg::status_t status;
	} response_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_wr_en = 1'b0;
	logic         cfg_wr_data = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [103:0] s_tdata = '0;   // address[31:0], byte_count[35:32], write_data[99:36], zero
	logic         s_tuser = lbr_pkg::CMD_READ;   // command
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;        // read_data[63:0]
	logic [1:0]   m_tuser;        // status

	lazy_block_ram_bus_device_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

	always #5 clk = ~clk;

	// --- predictor state: shadow of the memory, allocation bits and mode ---
	logic [7:0]  shadow_bytes [BLK_COUNT * BLK_BYTES];
	bit          shadow_alloc [BLK_COUNT];
	bit          fault_mode = 1'b0;

	response_t   pending_responses [$];   // expected results, oldest first
	int unsigned mismatches = 0;

	// traffic shaping, set by the test tasks
	int unsigned src_idle_pct = 0;
	int unsigned dst_idle_pct = 0;
	int unsigned write_limit = BLK_COUNT;   // random writes pick blocks below this, bar wild and end-of-memory picks
	int unsigned hold_requests = 0;         // bumped to ask the receiver for a long hold

	// Works out the result of one access and applies it to the shadow state.
	function automatic response_t predict_access(logic cmd, logic [31:0] addr,
			logic [3:0] cnt, logic [63:0] wdata);
		response_t       r;
		int unsigned     n;
		longint unsigned a;
		int unsigned     blk;
		r.read_data = '0;
		r.status = lbr_pkg::ST_OK;
		n = (cnt > MAX_BYTES) ? MAX_BYTES : cnt;
		// out of range, either at the start or running past the end
		if ({32'd0, addr} >= CAPACITY || n > CAPACITY - {32'd0, addr}) begin
			r.status = lbr_pkg::ST_UNMAPPED;
			return r;
		end
		if (cmd == lbr_pkg::CMD_WRITE) begin
			for (int i = 0; i < n; i++) begin
				a = {32'd0, addr} + i;
				blk = 32'(a / BLK_BYTES);
				if (!shadow_alloc[blk]) begin
					// first touch clears the whole block
					for (int j = 0; j < BLK_BYTES; j++)
						shadow_bytes[blk * BLK_BYTES + j] = 8'h00;
					shadow_alloc[blk] = 1'b1;
				end
				shadow_bytes[a] = wdata[8 * i +: 8];
			end
			return r;
		end
		for (int i = 0; i < n; i++) begin
			a = {32'd0, addr} + i;
			blk = 32'(a / BLK_BYTES);
			if (shadow_alloc[blk]) begin
				r.read_data[8 * i +: 8] = shadow_bytes[a];
			end else if (fault_mode) begin
				// any unallocated byte faults the whole read, data dropped
				r.read_data = '0;
				r.status = lbr_pkg::ST_FAULT;
				return r;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
		mismatches++;
	endtask

	// --- request side: one transfer per call, random gaps in front ---
	task automatic send_access(logic cmd, logic [31:0] addr, logic [3:0] cnt,
			logic [63:0] wdata);
		while ($urandom_range(99, 0) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {4'b0, wdata, cnt, addr};
		do
			@(posedge clk);
		while (!s_tready);
		// transfer happened at this edge; predict in acceptance order
		pending_responses.push_back(predict_access(cmd, addr, cnt, wdata));
	endtask

	// Sender goes quiet until every expected result is back.
	task automatic drain_responses();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_responses.size() != 0)
			@(posedge clk);
	endtask

	// Mode register is only touched with the block idle.
	task automatic set_uninit_mode(bit mode);
		drain_responses();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= mode;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		fault_mode = mode;
	endtask

	// --- response side: random stalls, long holds on request, checking ---
	always @(posedge clk) begin
		static int unsigned hold_seen = 0;
		static int unsigned hold_left = 0;
		response_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_responses.size() == 0) begin
					report_mismatch("unexpected result", m_tdata, '0);
				end else begin
					want = pending_responses.pop_front();
					if (m_tdata !== want.read_data)
						report_mismatch("read_data", m_tdata, want.read_data);
					if (m_tuser !== want.status)
						report_mismatch("status", 64'(m_tuser), 64'(want.status));
				end
			end
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99, 0) >= dst_idle_pct);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		static int unsigned quiet = 0;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("lazy_block_ram_bus_device_top_tb: FAIL");
				$finish;
			end
		end
	end

	// --- random item shaping ---
	function automatic logic [31:0] pick_address(bit for_write);
		int unsigned sel;
		int unsigned blk;
		int unsigned off;
		sel = $urandom_range(99, 0);
		if (sel < 8)
			return $urandom;   // wild address, nearly always unmapped
		if (sel < 12)
			return 32'(CAPACITY - $urandom_range(12, 0));   // hugging the end of memory
		if (for_write || sel < 70)
			blk = $urandom_range(write_limit - 1, 0);
		else
			blk = $urandom_range(BLK_COUNT - 1, 0);
		// near the block end to straddle blocks, else a small hot window
		if (sel < 45)
			off = BLK_BYTES - $urandom_range(8, 1);
		else
			off = $urandom_range(31, 0);
		return blk * BLK_BYTES + off;
	endfunction

	function automatic logic [3:0] pick_count();
		int unsigned sel;
		sel = $urandom_range(99, 0);
		if (sel < 10)
			return 4'd0;
		if (sel < 15)
			return 4'($urandom_range(15, MAX_BYTES + 1));   // saturates
		return 4'($urandom_range(MAX_BYTES, 1));
	endfunction

	task automatic send_random_access();
		logic cmd;
		cmd = ($urandom_range(99, 0) < 45) ? lbr_pkg::CMD_WRITE : lbr_pkg::CMD_READ;
		send_access(cmd, pick_address(cmd == lbr_pkg::CMD_WRITE), pick_count(),
			{$urandom, $urandom});
	endtask

	// --- tests ---

	// Zero-fill mode: range checks, saturation, straddling writes, read-back.
	task automatic test_zero_fill_reads();
		set_uninit_mode(1'b0);
		send_access(lbr_pkg::CMD_READ,  32'd0,         4'd8,  '0);   // unallocated -> zeros
		send_access(lbr_pkg::CMD_READ,  32'd0,         4'd0,  '0);   // empty access
		send_access(lbr_pkg::CMD_READ,  32'd16384,     4'd0,  '0);   // at capacity
		send_access(lbr_pkg::CMD_READ,  32'd16380,     4'd8,  '0);   // runs past the end
		send_access(lbr_pkg::CMD_READ,  32'd16376,     4'd8,  '0);   // last eight bytes
		send_access(lbr_pkg::CMD_WRITE, 32'hFFFF_FFFF, 4'd1,  64'hFFFF_FFFF_FFFF_FFFF);
		// spans two blocks
		send_access(lbr_pkg::CMD_WRITE, 32'd252,       4'd8,  64'hFFFF_FFFF_FFFF_FFFF);
		send_access(lbr_pkg::CMD_READ,  32'd250,       4'd15, '0);   // oversized count
		send_access(lbr_pkg::CMD_READ,  32'd256,       4'd4,  '0);
		send_access(lbr_pkg::CMD_WRITE, 32'd16376,     4'd8,  64'hA5C3_0F96_5A3C_F069);
		send_access(lbr_pkg::CMD_READ,  32'd16376,     4'd9,  '0);
		// zero length, no allocation
		send_access(lbr_pkg::CMD_WRITE, 32'd1000,      4'd0,  64'hDEAD_BEEF_0000_0001);
	endtask

	// Fault mode: unallocated reads, partly allocated reads, edge writes.
	task automatic test_fault_mode();
		set_uninit_mode(1'b1);
		send_access(lbr_pkg::CMD_READ,  32'd1000,      4'd1,  '0);   // block left unallocated
		send_access(lbr_pkg::CMD_READ,  32'd504,       4'd8,  '0);   // inside allocated block
		send_access(lbr_pkg::CMD_READ,  32'd508,       4'd8,  '0);   // second half unallocated
		send_access(lbr_pkg::CMD_READ,  32'd1024,      4'd0,  '0);   // empty read never faults
		send_access(lbr_pkg::CMD_WRITE, 32'd508,       4'd8,  64'h0123_4567_89AB_CDEF);
		send_access(lbr_pkg::CMD_READ,  32'd508,       4'd8,  '0);
		send_access(lbr_pkg::CMD_READ,  32'h8000_0000, 4'd4,  '0);
		send_access(lbr_pkg::CMD_WRITE, 32'd16383,     4'd2,  64'h0000_0000_0000_BBAA);
		send_access(lbr_pkg::CMD_WRITE, 32'd16383,     4'd1,  64'h0000_0000_0000_00EE);
		send_access(lbr_pkg::CMD_READ,  32'd16383,     4'd1,  '0);
	endtask

	// Receiver stops for a long stretch while requests keep coming.
	task automatic test_output_backpressure();
		src_idle_pct = 0;
		dst_idle_pct = 0;
		write_limit = 8;
		hold_requests++;
		repeat (30) send_random_access();
		drain_responses();
	endtask

	task automatic test_random_traffic(bit mode, int unsigned src_pct, int unsigned dst_pct,
			int unsigned blocks, int unsigned count, bit mid_pause);
		set_uninit_mode(mode);
		src_idle_pct = src_pct;
		dst_idle_pct = dst_pct;
		write_limit = blocks;
		for (int k = 0; k < count; k++) begin
			if (mid_pause && k == count / 2)
				drain_responses();
			send_random_access();
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_fill_reads();
		test_fault_mode();
		test_output_backpressure();
		// write targets widen phase by phase so unallocated blocks stay around
		test_random_traffic(1'b1, 11, 51, 20, 620, 1'b0);
		test_random_traffic(1'b0, 51, 11, 40, 620, 1'b0);
		test_random_traffic(1'b1, 0,  0,  BLK_COUNT, 620, 1'b1);

		drain_responses();
		repeat (SETTLE_CYCLES * 2) @(posedge clk);
		if (mismatches == 0 && pending_responses.size() == 0) begin
			$display("lazy_block_ram_bus_device_top_tb: PASS");
		end else begin
			$display("lazy_block_ram_bus_device_top_tb: FAIL");
		end
		$finish;
	end

endmodule

>>> lazy_block_ram_bus_device_top.f
src/lbr_pkg.sv
src/lbr_ctrl.sv
src/lbr_dp.sv
src/lazy_block_ram_bus_device_top.sv
src/lbr_check.sv
tb/lazy_block_ram_bus_device_top_tb.sv
